// ===== src/bliu_pkg.sv =====
// ----------------------------------------------------------------------------
// bliu_pkg
// Shared types, codes and header constants of the band line image unpacker.
// ----------------------------------------------------------------------------
package bliu_pkg;

  localparam int unsigned MaxWidth = 4096;

  // Header layout
  localparam logic [31:0] MagicHi     = 32'h48454144;  // "HEAD"
  localparam logic [15:0] MagicLo     = 16'h3734;      // "74"
  localparam logic [7:0]  HdrLen      = 8'h80;
  localparam logic [6:0]  HdrLastIdx  = 7'(HdrLen - 8'd1);
  localparam logic [6:0]  HdrMagicEnd = 7'd6;
  localparam logic [6:0]  HdrPlanes   = 7'h0a;
  localparam logic [6:0]  HdrWidthLo  = 7'h12;
  localparam logic [6:0]  HdrWidthHi  = 7'h13;
  localparam logic [6:0]  HdrHeightLo = 7'h16;
  localparam logic [6:0]  HdrHeightHi = 7'h17;

  // Result kinds
  localparam logic [1:0] KindHeader = 2'd0;
  localparam logic [1:0] KindRgb    = 2'd1;
  localparam logic [1:0] KindGray   = 2'd2;

  // Header status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadMagic = 2'd1;
  localparam logic [1:0] StatusTooWide  = 2'd2;

  // Plane order within a color row
  localparam logic [1:0] PlaneRed   = 2'd0;
  localparam logic [1:0] PlaneGreen = 2'd1;
  localparam logic [1:0] PlaneBlue  = 2'd2;

  typedef enum logic [2:0] {
    PhHeader = 3'b001,
    PhData   = 3'b010,
    PhDone   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } bliu_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  gray;
    logic [15:0] width_out;
    logic [15:0] height_out;
    logic        is_color;
    logic [1:0]  status;
    logic        final_pixel;
  } bliu_out_t;

  // Line store control from parser to store
  typedef struct packed {
    logic wr_red;
    logic wr_green;
    logic rd;
  } bliu_ls_req_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = MagicHi[31:24];
      3'd1:    b = MagicHi[23:16];
      3'd2:    b = MagicHi[15:8];
      3'd3:    b = MagicHi[7:0];
      3'd4:    b = MagicLo[15:8];
      3'd5:    b = MagicLo[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/bliu_line_store.sv =====
// ----------------------------------------------------------------------------
// bliu_line_store
// Red and green line memories; one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bliu_line_store #(
  parameter int unsigned MAX_WIDTH = bliu_pkg::MaxWidth,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                  clk_i,
  input  bliu_pkg::bliu_ls_req_t req_i,
  input  logic [AW-1:0]         addr_i,
  input  logic [7:0]            wr_data_i,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o
);

  logic [7:0] red_mem   [MAX_WIDTH];
  logic [7:0] green_mem [MAX_WIDTH];
  logic [7:0] red_q;
  logic [7:0] green_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_red) begin
      red_mem[addr_i] <= wr_data_i;
    end
    if (req_i.wr_green) begin
      green_mem[addr_i] <= wr_data_i;
    end
  end

  // Hold read data until the next blue item reads
  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      red_q   <= red_mem[addr_i];
      green_q <= green_mem[addr_i];
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;

endmodule

// ===== src/bliu_parser.sv =====
// ----------------------------------------------------------------------------
// bliu_parser
// Header parse and pixel position tracking; one item per accepted byte.
// ----------------------------------------------------------------------------
module bliu_parser #(
  parameter int unsigned MAX_WIDTH = bliu_pkg::MaxWidth,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  bliu_pkg::bliu_in_t     in_i,
  output logic                   res_valid_o,
  output bliu_pkg::bliu_out_t    res_o,
  output bliu_pkg::bliu_ls_req_t ls_req_o,
  output logic [AW-1:0]          ls_addr_o
);

  localparam logic [16:0] MaxWidth17 = 17'(MAX_WIDTH);

  logic [6:0]       hidx_q, hidx_e, hidx_d;
  bliu_pkg::phase_e phase_q, phase_e, phase_d;
  logic             magic_q, magic_e, magic_d;
  logic [15:0]      width_q, width_e, width_d;
  logic [15:0]      height_q, height_e, height_d;
  logic             color_q, color_e, color_d;
  logic [15:0]      col_q, col_e, col_d;
  logic [1:0]       plane_q, plane_e, plane_d;
  logic [15:0]      row_q, row_e, row_d;

  logic [7:0]  b;
  logic [1:0]  status;
  logic        last_col, last_row;

  assign b = in_i.data_byte;

  // Start of file restarts the parse for this very byte
  always_comb begin
    if (in_i.start_of_file) begin
      hidx_e   = '0;
      phase_e  = bliu_pkg::PhHeader;
      magic_e  = 1'b1;
      width_e  = '0;
      height_e = '0;
      color_e  = 1'b0;
      col_e    = '0;
      plane_e  = bliu_pkg::PlaneRed;
      row_e    = '0;
    end else begin
      hidx_e   = hidx_q;
      phase_e  = phase_q;
      magic_e  = magic_q;
      width_e  = width_q;
      height_e = height_q;
      color_e  = color_q;
      col_e    = col_q;
      plane_e  = plane_q;
      row_e    = row_q;
    end
  end

  assign last_col = (({1'b0, col_e} + 17'd1) == {1'b0, width_e});
  assign last_row = (({1'b0, row_e} + 17'd1) == {1'b0, height_e});

  always_comb begin
    hidx_d      = hidx_e;
    phase_d     = phase_e;
    magic_d     = magic_e;
    width_d     = width_e;
    height_d    = height_e;
    color_d     = color_e;
    col_d       = col_e;
    plane_d     = plane_e;
    row_d       = row_e;
    res_valid_o = 1'b0;
    res_o       = '0;
    ls_req_o    = '0;
    ls_addr_o   = col_e[AW-1:0];
    status      = bliu_pkg::StatusOk;

    case (phase_e)
      bliu_pkg::PhHeader: begin
        if (hidx_e < bliu_pkg::HdrMagicEnd && b != bliu_pkg::magic_byte(hidx_e[2:0])) begin
          magic_d = 1'b0;
        end
        if (hidx_e == bliu_pkg::HdrPlanes)   color_d = (b != 8'd1);
        if (hidx_e == bliu_pkg::HdrWidthLo)  width_d[7:0]   = b;
        if (hidx_e == bliu_pkg::HdrWidthHi)  width_d[15:8]  = b;
        if (hidx_e == bliu_pkg::HdrHeightLo) height_d[7:0]  = b;
        if (hidx_e == bliu_pkg::HdrHeightHi) height_d[15:8] = b;
        if (hidx_e != bliu_pkg::HdrLastIdx) begin
          hidx_d = hidx_e + 7'd1;
        end else begin
          if (!magic_e) begin
            status = bliu_pkg::StatusBadMagic;
          end else if (color_e && ({1'b0, width_e} > MaxWidth17)) begin
            status = bliu_pkg::StatusTooWide;
          end
          res_valid_o  = 1'b1;
          res_o.kind   = bliu_pkg::KindHeader;
          res_o.status = status;
          if (status != bliu_pkg::StatusBadMagic) begin
            res_o.width_out  = width_e;
            res_o.height_out = height_e;
            res_o.is_color   = color_e;
          end
          col_d   = '0;
          plane_d = bliu_pkg::PlaneRed;
          row_d   = '0;
          if (status != bliu_pkg::StatusOk || width_e == '0 || height_e == '0) begin
            phase_d = bliu_pkg::PhDone;
          end else begin
            phase_d = bliu_pkg::PhData;
          end
        end
      end

      bliu_pkg::PhData: begin
        if (!color_e) begin
          res_valid_o = 1'b1;
          res_o.kind  = bliu_pkg::KindGray;
          res_o.gray  = b;
          if (last_col && last_row) begin
            res_o.final_pixel = 1'b1;
            phase_d           = bliu_pkg::PhDone;
          end
          if (last_col) begin
            col_d = '0;
            row_d = row_e + 16'd1;
          end else begin
            col_d = col_e + 16'd1;
          end
        end else if ({1'b0, col_e} >= MaxWidth17) begin
          phase_d = bliu_pkg::PhDone;
        end else begin
          if (plane_e == bliu_pkg::PlaneRed) begin
            ls_req_o.wr_red = 1'b1;
          end else if (plane_e == bliu_pkg::PlaneGreen) begin
            ls_req_o.wr_green = 1'b1;
          end else begin
            ls_req_o.rd = 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = bliu_pkg::KindRgb;
            res_o.blue  = b;
            if (last_col && last_row) begin
              res_o.final_pixel = 1'b1;
              phase_d           = bliu_pkg::PhDone;
            end
          end
          if (last_col) begin
            col_d = '0;
            if (plane_e >= bliu_pkg::PlaneBlue) begin
              plane_d = bliu_pkg::PlaneRed;
              row_d   = row_e + 16'd1;
            end else begin
              plane_d = plane_e + 2'd1;
            end
          end else begin
            col_d = col_e + 16'd1;
          end
        end
      end

      default: begin
        // Past the image end or after an error: drop
      end
    endcase

    // Touch the line store only for an accepted item; hold read data otherwise
    if (!step_i) begin
      ls_req_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hidx_q   <= '0;
      phase_q  <= bliu_pkg::PhHeader;
      magic_q  <= 1'b1;
      width_q  <= '0;
      height_q <= '0;
      color_q  <= 1'b0;
      col_q    <= '0;
      plane_q  <= bliu_pkg::PlaneRed;
      row_q    <= '0;
    end else if (step_i) begin
      hidx_q   <= hidx_d;
      phase_q  <= phase_d;
      magic_q  <= magic_d;
      width_q  <= width_d;
      height_q <= height_d;
      color_q  <= color_d;
      col_q    <= col_d;
      plane_q  <= plane_d;
      row_q    <= row_d;
    end
  end

endmodule

// ===== src/band_line_image_unpack.sv =====
// ----------------------------------------------------------------------------
// band_line_image_unpack
// Byte stream image unpacker: header result, then gray or RGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_i) takes one file byte per
//   item; start_of_file marks header byte 0 of a new file. The output channel
//   (out_valid_o / out_ready_i / out_o) gives at most one result per byte: a
//   header result on header byte 0x7f, then one gray pixel per data byte, or
//   for color files one RGB pixel per blue byte after its red and green lines.
//   The result of a byte accepted at a clock edge is registered at that edge
//   and on out_o in the next cycle. Throughput is one byte per cycle while
//   in_ready_o is high; bytes that make no result (header, red, green,
//   trailing bytes) still take a step of their own. The red and green lines
//   sit in two line memories with one write or one registered read per cycle.
//   While the receiver stalls, the output register holds and in_ready_o
//   drops only when a result is waiting and out_ready_i is low.
//   Reset clears the parse to header byte 0 and empties the output register;
//   the line memories need no clearing.
// ----------------------------------------------------------------------------
module band_line_image_unpack #(
  parameter int unsigned MAX_WIDTH = bliu_pkg::MaxWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bliu_pkg::bliu_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bliu_pkg::bliu_out_t out_o
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                   step;
  logic                   res_valid;
  bliu_pkg::bliu_out_t    res;
  bliu_pkg::bliu_ls_req_t ls_req;
  logic [AW-1:0]          ls_addr;
  logic [7:0]             ls_red, ls_green;

  logic                   out_valid_q, out_valid_d;
  bliu_pkg::bliu_out_t    out_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  bliu_parser #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ls_req_o    (ls_req),
    .ls_addr_o   (ls_addr)
  );

  bliu_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .req_i     (ls_req),
    .addr_i    (ls_addr),
    .wr_data_i (in_i.data_byte),
    .red_o     (ls_red),
    .green_o   (ls_green)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  // Merge line store data into RGB items
  always_comb begin
    out_o = out_q;
    if (out_q.kind == bliu_pkg::KindRgb) begin
      out_o.red   = ls_red;
      out_o.green = ls_green;
    end
  end

  assign out_valid_o = out_valid_q;

  a_ls_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> $onehot0({ls_req.wr_red, ls_req.wr_green, ls_req.rd}))
    else $error("line store accessed twice in one step");

  a_rd_gives_rgb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && ls_req.rd |=> out_valid_o && out_o.kind == bliu_pkg::KindRgb)
    else $error("line store read without rgb item");

  a_final_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.final_pixel |-> out_o.kind != bliu_pkg::KindHeader)
    else $error("final_pixel on header item");

  a_bad_magic_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.kind == bliu_pkg::KindHeader &&
    out_o.status == bliu_pkg::StatusBadMagic
    |-> out_o.width_out == '0 && out_o.height_out == '0 && !out_o.is_color)
    else $error("bad magic header carries size");

endmodule

// ===== dv/band_line_image_unpack_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// band_line_image_unpack_test
// Self-checking bench for the byte stream image unpacker. A table of directed
// files (bad magic, too wide, empty, widest, truncated, restarts) is followed
// by random files. Both handshakes idle at random. Every result is checked
// field by field against a software predictor of the parser and line store.
// ----------------------------------------------------------------------------
module band_line_image_unpack_test;

  localparam int          RandomItems   = 800;
  localparam int          MaxGap        = 14;
  localparam int          DrainCycles   = 8;
  localparam int          NoBadByte     = 6;
  localparam logic [47:0] HeadTag       = {bliu_pkg::MagicHi, bliu_pkg::MagicLo};

  typedef struct packed {
    bit          sof;
    int          bad_at;
    logic [7:0]  planes;
    logic [15:0] w;
    logic [15:0] h;
    int          hdr_len;
    int          data_len;
    bit          typed;
    logic [1:0]  exp_status;
    bit          exp_color;
  } file_plan_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  bliu_pkg::bliu_in_t  in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  bliu_pkg::bliu_out_t out_item;

  bit        calm;
  int        mismatches;
  int        bytes_parsed;
  int        results_due_total;
  int        results_seen;
  int        files_sent;

  // Predictor state
  logic [6:0]          p_hdr_idx;
  bliu_pkg::phase_e    p_phase;
  logic                p_magic_good;
  logic [15:0]         p_width;
  logic [15:0]         p_height;
  logic                p_color;
  logic [15:0]         p_col;
  logic [1:0]          p_plane;
  logic [15:0]         p_row;
  logic [7:0]          red_line [bliu_pkg::MaxWidth];
  logic [7:0]          green_line [bliu_pkg::MaxWidth];
  bliu_pkg::bliu_out_t pixels_due [$];

  file_plan_t  plan [15];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  band_line_image_unpack dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_item)
  );

  function automatic logic [7:0] tag_byte(input int idx);
    return HeadTag[47 - 8 * idx -: 8];
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic void clear_parse();
    p_hdr_idx    = '0;
    p_phase      = bliu_pkg::PhHeader;
    p_magic_good = 1'b1;
    p_width      = '0;
    p_height     = '0;
    p_color      = 1'b0;
    p_col        = '0;
    p_plane      = bliu_pkg::PlaneRed;
    p_row        = '0;
  endfunction

  // Advance the parser by one byte; return 1 when the byte yields a result.
  function automatic bit unpack_byte(input bliu_pkg::bliu_in_t it,
                                     output bliu_pkg::bliu_out_t res);
    logic [7:0] b;
    logic [1:0] st;
    bit         last_col;
    bit         last_row;
    bit         got;
    b   = it.data_byte;
    res = '0;
    got = 1'b0;
    if (it.start_of_file) clear_parse();
    if (p_phase == bliu_pkg::PhHeader) begin
      if (p_hdr_idx < bliu_pkg::HdrMagicEnd && b != tag_byte(p_hdr_idx)) begin
        p_magic_good = 1'b0;
      end
      if (p_hdr_idx == bliu_pkg::HdrPlanes) p_color = (b != 8'd1);
      if (p_hdr_idx == bliu_pkg::HdrWidthLo) p_width[7:0] = b;
      if (p_hdr_idx == bliu_pkg::HdrWidthHi) p_width[15:8] = b;
      if (p_hdr_idx == bliu_pkg::HdrHeightLo) p_height[7:0] = b;
      if (p_hdr_idx == bliu_pkg::HdrHeightHi) p_height[15:8] = b;
      if (p_hdr_idx != bliu_pkg::HdrLastIdx) begin
        p_hdr_idx = p_hdr_idx + 7'd1;
        return 1'b0;
      end
      if (!p_magic_good) st = bliu_pkg::StatusBadMagic;
      else if (p_color && p_width > bliu_pkg::MaxWidth) st = bliu_pkg::StatusTooWide;
      else st = bliu_pkg::StatusOk;
      res.kind = bliu_pkg::KindHeader;
      if (st != bliu_pkg::StatusBadMagic) begin
        res.width_out  = p_width;
        res.height_out = p_height;
        res.is_color   = p_color;
      end
      res.status = st;
      p_col      = '0;
      p_plane    = bliu_pkg::PlaneRed;
      p_row      = '0;
      if (st != bliu_pkg::StatusOk || p_width == 0 || p_height == 0) begin
        p_phase = bliu_pkg::PhDone;
      end else begin
        p_phase = bliu_pkg::PhData;
      end
      return 1'b1;
    end
    if (p_phase != bliu_pkg::PhData) return 1'b0;

    last_col = (32'(p_col) + 1 == 32'(p_width));
    last_row = (32'(p_row) + 1 == 32'(p_height));

    if (!p_color) begin
      res.kind = bliu_pkg::KindGray;
      res.gray = b;
      if (last_col && last_row) begin
        res.final_pixel = 1'b1;
        p_phase = bliu_pkg::PhDone;
      end
      if (last_col) begin
        p_col = '0;
        p_row = p_row + 16'd1;
      end else begin
        p_col = p_col + 16'd1;
      end
      return 1'b1;
    end

    if (p_col >= bliu_pkg::MaxWidth) begin
      p_phase = bliu_pkg::PhDone;
      return 1'b0;
    end
    case (p_plane)
      bliu_pkg::PlaneRed:   red_line[p_col] = b;
      bliu_pkg::PlaneGreen: green_line[p_col] = b;
      default: begin
        got       = 1'b1;
        res.kind  = bliu_pkg::KindRgb;
        res.red   = red_line[p_col];
        res.green = green_line[p_col];
        res.blue  = b;
        if (last_col && last_row) begin
          res.final_pixel = 1'b1;
          p_phase = bliu_pkg::PhDone;
        end
      end
    endcase
    if (last_col) begin
      p_col = '0;
      if (p_plane >= bliu_pkg::PlaneBlue) begin
        p_plane = bliu_pkg::PlaneRed;
        p_row   = p_row + 16'd1;
      end else begin
        p_plane = p_plane + 2'd1;
      end
    end else begin
      p_col = p_col + 16'd1;
    end
    return got;
  endfunction

  task automatic flag(input string msg);
    mismatches++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v)
      flag($sformatf("%s mismatch: expected %0h, actual %0h", name, want_v, got_v));
  endtask

  // Offer one byte, wait for its acceptance, then predict what it yields.
  task automatic send_byte(input logic [7:0] b, input logic sof, input bit typed,
                           input bliu_pkg::bliu_out_t typed_hdr);
    bliu_pkg::bliu_in_t  it;
    bliu_pkg::bliu_out_t res;
    int                  gap;
    it.data_byte     = b;
    it.start_of_file = sof;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (sof || p_phase != bliu_pkg::PhDone) bytes_parsed++;
    if (unpack_byte(it, res)) begin
      if (typed && res.kind == bliu_pkg::KindHeader) res = typed_hdr;
      pixels_due.push_back(res);
      results_due_total++;
    end
  endtask

  task automatic send_file(input file_plan_t fp, input bit extremes);
    logic [7:0]          b;
    bliu_pkg::bliu_out_t th;
    th        = '0;
    th.kind   = bliu_pkg::KindHeader;
    th.status = fp.exp_status;
    if (fp.exp_status != bliu_pkg::StatusBadMagic) begin
      th.width_out  = fp.w;
      th.height_out = fp.h;
      th.is_color   = fp.exp_color;
    end
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < fp.hdr_len; i++) begin
      b = 8'($urandom);
      if (i < NoBadByte)
        b = tag_byte(i) ^ ((i == fp.bad_at) ? 8'($urandom_range(1, 255)) : 8'h00);
      else if (i == bliu_pkg::HdrPlanes) b = fp.planes;
      else if (i == bliu_pkg::HdrWidthLo) b = fp.w[7:0];
      else if (i == bliu_pkg::HdrWidthHi) b = fp.w[15:8];
      else if (i == bliu_pkg::HdrHeightLo) b = fp.h[7:0];
      else if (i == bliu_pkg::HdrHeightHi) b = fp.h[15:8];
      send_byte(b, (i == 0) ? fp.sof : 1'b0, fp.typed, th);
    end
    for (int k = 0; k < fp.data_len; k++) begin
      b = 8'($urandom);
      if (extremes && k % 3 == 0) b = 8'h00;
      else if (extremes && k % 3 == 1) b = 8'hff;
      send_byte(b, 1'b0, 1'b0, th);
    end
    files_sent++;
  endtask

  // Mostly well-formed small images; the rest breaks the header or the data.
  task automatic send_random_file();
    file_plan_t fp;
    int         sel;
    int         full;
    fp          = '0;
    fp.sof      = 1'b1;
    fp.bad_at   = NoBadByte;
    fp.hdr_len  = bliu_pkg::HdrLen;
    fp.planes   = $urandom_range(0, 1) ? 8'd1 : 8'($urandom);
    fp.w        = 16'($urandom_range(1, 12));
    fp.h        = 16'($urandom_range(1, 4));
    full        = ((fp.planes == 8'd1) ? 1 : 3) * fp.w * fp.h;
    fp.data_len = full + $urandom_range(0, 3);
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      fp.bad_at = $urandom_range(0, 5);
    end else if (sel < 10) begin
      fp.planes   = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(2, 255));
      fp.w        = 16'($urandom_range(bliu_pkg::MaxWidth + 1, 65535));
      fp.data_len = $urandom_range(0, 8);
    end else if (sel < 13) begin
      fp.hdr_len  = $urandom_range(1, bliu_pkg::HdrLen - 1);
      fp.data_len = 0;
    end else if (sel < 17) begin
      fp.data_len = $urandom_range(0, full - 1);
    end else if (sel < 20) begin
      if ($urandom_range(0, 1)) fp.w = '0;
      else fp.h = '0;
      fp.data_len = $urandom_range(0, 5);
    end else if (sel < 23) begin
      fp.sof = 1'b0;
    end
    send_file(fp, 1'b0);
  endtask

  initial begin : result_check
    bliu_pkg::bliu_out_t want;
    int                  gap;
    @(posedge rst_n);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      results_seen++;
      if (pixels_due.size() == 0) begin
        flag($sformatf("unexpected item: expected none, actual %p", out_item));
      end else begin
        want = pixels_due.pop_front();
        check_field("kind", want.kind, out_item.kind);
        check_field("red", want.red, out_item.red);
        check_field("green", want.green, out_item.green);
        check_field("blue", want.blue, out_item.blue);
        check_field("gray", want.gray, out_item.gray);
        check_field("width_out", want.width_out, out_item.width_out);
        check_field("height_out", want.height_out, out_item.height_out);
        check_field("is_color", want.is_color, out_item.is_color);
        check_field("status", want.status, out_item.status);
        check_field("final_pixel", want.final_pixel, out_item.final_pixel);
      end
    end
  end

  initial begin : stimulus
    int items_mark;
    // sof, bad byte, planes, width, height, header bytes, data bytes,
    // typed header, status, color
    plan = '{
      // no start_of_file after reset, two trailing bytes
      '{1'b0, NoBadByte, 8'd1, 16'd3, 16'd2, bliu_pkg::HdrLen, 8, 1'b1,
        bliu_pkg::StatusOk, 1'b0},
      '{1'b1, 2, 8'd3, 16'd4, 16'd2, bliu_pkg::HdrLen, 10, 1'b1,
        bliu_pkg::StatusBadMagic, 1'b0},
      '{1'b1, NoBadByte, 8'd3, 16'd4097, 16'd1, bliu_pkg::HdrLen, 6, 1'b1,
        bliu_pkg::StatusTooWide, 1'b1},
      // widest color line the store holds; red line cut short by the next file
      '{1'b1, NoBadByte, 8'd3, 16'd4096, 16'd1, bliu_pkg::HdrLen, 24, 1'b1,
        bliu_pkg::StatusOk, 1'b1},
      '{1'b1, NoBadByte, 8'd1, 16'd0, 16'd5, bliu_pkg::HdrLen, 3, 1'b1,
        bliu_pkg::StatusOk, 1'b0},
      '{1'b1, NoBadByte, 8'd3, 16'd5, 16'd0, bliu_pkg::HdrLen, 4, 1'b1,
        bliu_pkg::StatusOk, 1'b1},
      // gray has no width limit; cut short by the next file
      '{1'b1, NoBadByte, 8'd1, 16'hffff, 16'hffff, bliu_pkg::HdrLen, 20, 1'b1,
        bliu_pkg::StatusOk, 1'b0},
      '{1'b1, NoBadByte, 8'd0, 16'd2, 16'd2, bliu_pkg::HdrLen, 14, 1'b0,
        bliu_pkg::StatusOk, 1'b0},
      '{1'b1, NoBadByte, 8'd255, 16'd1, 16'd1, bliu_pkg::HdrLen, 4, 1'b0,
        bliu_pkg::StatusOk, 1'b0},
      '{1'b1, NoBadByte, 8'd1, 16'd1, 16'd1, bliu_pkg::HdrLen, 2, 1'b0,
        bliu_pkg::StatusOk, 1'b0},
      // restart inside the header, then inside the data
      '{1'b1, NoBadByte, 8'd1, 16'd2, 16'd2, 50, 0, 1'b0,
        bliu_pkg::StatusOk, 1'b0},
      '{1'b1, NoBadByte, 8'd3, 16'd3, 16'd3, bliu_pkg::HdrLen, 5, 1'b0,
        bliu_pkg::StatusOk, 1'b0},
      '{1'b1, 5, 8'd1, 16'd2, 16'd1, bliu_pkg::HdrLen, 3, 1'b1,
        bliu_pkg::StatusBadMagic, 1'b0},
      '{1'b1, 0, 8'd1, 16'hffff, 16'hffff, bliu_pkg::HdrLen, 3, 1'b1,
        bliu_pkg::StatusBadMagic, 1'b0},
      '{1'b1, NoBadByte, 8'd1, 16'd8, 16'd3, bliu_pkg::HdrLen, 24, 1'b0,
        bliu_pkg::StatusOk, 1'b0}
    };
    clear_parse();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (plan[k]) send_file(plan[k], 1'b1);
    items_mark = bytes_parsed;
    while (bytes_parsed - items_mark < RandomItems)
      send_random_file();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d files, %0d parsed bytes, %0d results received, %0d mismatches",
             files_sent, bytes_parsed, results_seen, mismatches);
    if (mismatches == 0 && pixels_due.size() == 0) begin
      $display("band_line_image_unpack regression: pass");
    end else begin
      $display("band_line_image_unpack regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timed out with %0d results still due", pixels_due.size());
    $display("band_line_image_unpack regression: fail");
    $finish;
  end

endmodule
